FILE: design/hva_pkg.sv
// Shared types, operation codes and constants for the four-component vector ALU.
package hva_pkg;

    localparam int EPS_W       = 17;
    localparam int SQRT_STAGES = 32;
    localparam int DEN_W       = 33;

    localparam logic [EPS_W-1:0] EPS_RESET = 17'd1;

    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    localparam int BYTE_MUL    = 255999;
    localparam int BYTE_LIMIT  = 256000;
    localparam int BYTE_MAX    = 255;
    localparam int RECIP_1000  = 268436;
    localparam int RECIP_SHIFT = 28;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIVZ = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_NEG   = 4'd2,
        OP_SCALE = 4'd3,
        OP_DIV   = 4'd4,
        OP_EQ    = 4'd5,
        OP_MAG   = 4'd6,
        OP_NORM  = 4'd7,
        OP_DOT   = 4'd8,
        OP_CROSS = 4'd9,
        OP_CPROD = 4'd10,
        OP_BYTES = 4'd11
    } op_t;

    typedef struct packed {
        logic [3:0]         operation;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] a_w;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] b_w;
        logic signed [31:0] factor;
    } in_t;

    typedef struct packed {
        logic signed [31:0] res_x;
        logic signed [31:0] res_y;
        logic signed [31:0] res_z;
        logic signed [31:0] res_w;
        logic signed [31:0] res_scalar;
        logic               is_equal;
        logic [1:0]         status;
    } out_t;

    typedef struct packed {
        logic signed [31:0] val;
        logic               sat;
    } sat_t;

    typedef struct packed {
        logic signed [31:0] r;
        logic               sat;
        logic               eq;
        logic signed [63:0] prod;
    } lane_out_t;

    function automatic sat_t sat32(input logic signed [67:0] v);
        sat_t s;
        s.sat = 1'b1;
        if (v > 68'(S32_MAX)) begin
            s.val = 32'(S32_MAX);
        end else if (v < 68'(S32_MIN)) begin
            s.val = 32'(S32_MIN);
        end else begin
            s.val = v[31:0];
            s.sat = 1'b0;
        end
        return s;
    endfunction

endpackage

FILE: design/hva_lane.sv
// One component lane: add/sub/negate, products, epsilon compare and byte conversion.
module hva_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [3:0]                    op,
    input  logic signed [31:0]            a,
    input  logic signed [31:0]            b,
    input  logic signed [31:0]            ca1,
    input  logic signed [31:0]            cb1,
    input  logic signed [31:0]            ca2,
    input  logic signed [31:0]            cb2,
    input  logic signed [31:0]            f,
    input  logic [hva_pkg::EPS_W-1:0]     eps,
    output hva_pkg::lane_out_t            lane_o
);

    logic signed [32:0] diff;
    logic [32:0]        absd;
    logic               eq_next;
    logic signed [33:0] lin_next;
    logic signed [31:0] x1, y1, x2, y2;

    logic [3:0]         op1_reg;
    logic signed [33:0] lin_reg;
    logic signed [63:0] mul1_reg;
    logic signed [63:0] mul2_reg;
    logic               eq1_reg;

    logic signed [64:0] pdiff;
    logic signed [64:0] pshift;
    logic signed [63:0] bv;
    logic [36:0]        bq;
    hva_pkg::sat_t      s;
    hva_pkg::lane_out_t lane_next;
    hva_pkg::lane_out_t lane_reg;

    always_comb begin
        diff     = 33'(a) - 33'(b);
        absd     = diff[32] ? 33'(-diff) : 33'(diff);
        eq_next  = absd < 33'(eps);
        lin_next = '0;
        x1 = a;
        y1 = '0;
        x2 = '0;
        y2 = '0;
        unique case (op)
            hva_pkg::OP_ADD:   lin_next = 34'(a) + 34'(b);
            hva_pkg::OP_SUB:   lin_next = 34'(a) - 34'(b);
            hva_pkg::OP_NEG:   lin_next = -34'(a);
            hva_pkg::OP_SCALE: y1 = f;
            hva_pkg::OP_DOT, hva_pkg::OP_CPROD: y1 = b;
            hva_pkg::OP_MAG, hva_pkg::OP_NORM:  y1 = a;
            hva_pkg::OP_BYTES: y1 = 32'(hva_pkg::BYTE_MUL);
            hva_pkg::OP_CROSS: begin
                x1 = ca1;
                y1 = cb1;
                x2 = ca2;
                y2 = cb2;
            end
            default: x1 = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op1_reg  <= op;
            lin_reg  <= lin_next;
            mul1_reg <= x1 * y1;
            mul2_reg <= x2 * y2;
            eq1_reg  <= eq_next;
        end
    end

    always_comb begin
        pdiff  = 65'(mul1_reg) - 65'(mul2_reg);
        pshift = pdiff >>> FRAC_BITS;
        bv     = mul1_reg >>> FRAC_BITS;
        bq     = 37'(bv[17:0]) * 37'(hva_pkg::RECIP_1000);
        s      = '0;
        lane_next.r    = '0;
        lane_next.sat  = 1'b0;
        lane_next.eq   = eq1_reg;
        lane_next.prod = mul1_reg;
        unique case (op1_reg)
            hva_pkg::OP_ADD, hva_pkg::OP_SUB, hva_pkg::OP_NEG: begin
                s = hva_pkg::sat32(68'(lin_reg));
                lane_next.r   = s.val;
                lane_next.sat = s.sat;
            end
            hva_pkg::OP_SCALE, hva_pkg::OP_CROSS, hva_pkg::OP_CPROD: begin
                s = hva_pkg::sat32(68'(pshift));
                lane_next.r   = s.val;
                lane_next.sat = s.sat;
            end
            hva_pkg::OP_BYTES: begin
                if (mul1_reg <= 0) begin
                    lane_next.r = '0;
                end else if (bv >= 64'(hva_pkg::BYTE_LIMIT)) begin
                    lane_next.r = 32'(hva_pkg::BYTE_MAX);
                end else begin
                    lane_next.r = 32'(bq[hva_pkg::RECIP_SHIFT+7:hva_pkg::RECIP_SHIFT]);
                end
            end
            default: lane_next.r = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lane_reg <= lane_next;
        end
    end

    assign lane_o = lane_reg;

endmodule

FILE: design/hva_isqrt.sv
// Pipelined integer square root of a 64-bit value, one result bit per stage.
module hva_isqrt (
    input  logic        aclk,
    input  logic        en,
    input  logic [63:0] n_in,
    output logic [31:0] root_out
);

    localparam int N = hva_pkg::SQRT_STAGES;

    logic [33:0] rem_reg  [N];
    logic [31:0] root_reg [N];
    logic [63:0] n_reg    [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [33:0] rem_p;
        logic [31:0] root_p;
        logic [63:0] n_p;
        logic [35:0] t;
        logic [35:0] trial;
        logic [33:0] rem_n;
        logic [31:0] root_n;

        if (k == 0) begin : g_first
            assign rem_p  = '0;
            assign root_p = '0;
            assign n_p    = n_in;
        end else begin : g_next
            assign rem_p  = rem_reg[k-1];
            assign root_p = root_reg[k-1];
            assign n_p    = n_reg[k-1];
        end

        always_comb begin
            t     = {rem_p, n_p[63-2*k -: 2]};
            trial = {2'b00, root_p, 2'b01};
            if (t >= trial) begin
                rem_n  = 34'(t - trial);
                root_n = {root_p[30:0], 1'b1};
            end else begin
                rem_n  = t[33:0];
                root_n = {root_p[30:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_n;
                root_reg[k] <= root_n;
                n_reg[k]    <= n_p;
            end
        end
    end

    assign root_out = root_reg[N-1];

endmodule

FILE: design/hva_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
module hva_div #(
    parameter int NW = 48
) (
    input  logic                      aclk,
    input  logic                      en,
    input  logic [NW-1:0]             num_in,
    input  logic [hva_pkg::DEN_W-1:0] den_in,
    output logic [NW-1:0]             q_out
);

    localparam int DW = hva_pkg::DEN_W;

    logic [DW-1:0] rem_reg [NW];
    logic [NW-1:0] q_reg   [NW];
    logic [NW-1:0] num_reg [NW];
    logic [DW-1:0] den_reg [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [DW-1:0] rem_p;
        logic [NW-1:0] q_p;
        logic [NW-1:0] num_p;
        logic [DW-1:0] den_p;
        logic [DW:0]   t;
        logic [DW-1:0] rem_n;
        logic          qb;

        if (k == 0) begin : g_first
            assign rem_p = '0;
            assign q_p   = '0;
            assign num_p = num_in;
            assign den_p = den_in;
        end else begin : g_next
            assign rem_p = rem_reg[k-1];
            assign q_p   = q_reg[k-1];
            assign num_p = num_reg[k-1];
            assign den_p = den_reg[k-1];
        end

        always_comb begin
            t = {rem_p, num_p[NW-1-k]};
            if (t >= {1'b0, den_p}) begin
                rem_n = DW'(t - {1'b0, den_p});
                qb    = 1'b1;
            end else begin
                rem_n = t[DW-1:0];
                qb    = 1'b0;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= rem_n;
                q_reg[k]   <= {q_p[NW-2:0], qb};
                num_reg[k] <= num_p;
                den_reg[k] <= den_p;
            end
        end
    end

    assign q_out = q_reg[NW-1];

endmodule

FILE: design/homogeneous_vector_alu.sv
// Four-component Q fixed-point vector ALU, top level.
// Throughput: one transfer per cycle while the output is not stalled; all operations
// share one fixed-depth pipeline, set by the 32-stage square root followed by the
// (32 + FRAC_BITS)-stage divider lanes.
// The whole pipeline holds while a result waits on the output register.
// Reset clears the valid pipe and sets epsilon to 1; payload registers are not reset.
module homogeneous_vector_alu #(
    parameter int FRAC_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  hva_pkg::in_t              s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output hva_pkg::out_t             m_data,
    input  logic                      cfg_we,
    input  logic [hva_pkg::EPS_W-1:0] cfg_wdata
);

    localparam int SQ     = hva_pkg::SQRT_STAGES;
    localparam int DIVN   = 32 + FRAC_BITS;
    localparam int SIDE_N = SQ + DIVN + 1;
    localparam int LAT    = SQ + DIVN + 4;

    typedef struct packed {
        logic [3:0]       op;
        logic [3:0][31:0] r;
        logic [3:0]       lsat;
        logic             eq;
        logic [31:0]      dot;
        logic             dsat;
        logic             big;
        logic [3:0][31:0] a;
        logic [31:0]      f;
        logic [32:0]      m;
    } side_t;

    logic [hva_pkg::EPS_W-1:0] eps_reg;
    logic [LAT-1:0]            vld_reg;
    logic                      adv;

    logic signed [31:0] a_in [4];
    logic signed [31:0] b_in [4];
    logic signed [31:0] ca1  [4];
    logic signed [31:0] cb1  [4];
    logic signed [31:0] ca2  [4];
    logic signed [31:0] cb2  [4];

    hva_pkg::in_t       in1_reg;
    hva_pkg::in_t       in2_reg;
    hva_pkg::lane_out_t lane_o [4];

    logic signed [65:0] dsum;
    logic signed [65:0] dsh;
    logic [65:0]        qsum;
    hva_pkg::sat_t      dsat;
    side_t              mrg;
    side_t              side_reg [SIDE_N];
    logic [63:0]        sqn_reg;
    logic [31:0]        root;

    side_t               sd_q;
    side_t               div_side;
    logic [32:0]         m_val;
    logic [31:0]         fabs;
    logic [31:0]         aabs [4];
    logic [DIVN-1:0]     num  [4];
    logic [32:0]         den  [4];
    logic [DIVN-1:0]     quo  [4];

    side_t               sd;
    logic                neg  [4];
    logic signed [67:0]  qv   [4];
    hva_pkg::sat_t       qs   [4];
    logic                sat;
    logic                dz;
    hva_pkg::out_t       out_next;
    hva_pkg::out_t       out_reg;

    assign adv     = !vld_reg[LAT-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[LAT-1];
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= hva_pkg::EPS_RESET;
        end else if (cfg_we) begin
            eps_reg <= cfg_wdata;
        end
    end

    always_comb begin
        a_in[0] = s_data.a_x;
        a_in[1] = s_data.a_y;
        a_in[2] = s_data.a_z;
        a_in[3] = s_data.a_w;
        b_in[0] = s_data.b_x;
        b_in[1] = s_data.b_y;
        b_in[2] = s_data.b_z;
        b_in[3] = s_data.b_w;
        ca1[0] = a_in[1]; cb1[0] = b_in[2]; ca2[0] = a_in[2]; cb2[0] = b_in[1];
        ca1[1] = a_in[2]; cb1[1] = b_in[0]; ca2[1] = a_in[0]; cb2[1] = b_in[2];
        ca1[2] = a_in[0]; cb1[2] = b_in[1]; ca2[2] = a_in[1]; cb2[2] = b_in[0];
        ca1[3] = '0;      cb1[3] = '0;      ca2[3] = '0;      cb2[3] = '0;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            in1_reg <= s_data;
            in2_reg <= in1_reg;
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_lane
        hva_lane #(
            .FRAC_BITS(FRAC_BITS)
        ) u_lane (
            .aclk   (aclk),
            .en     (adv),
            .op     (s_data.operation),
            .a      (a_in[g]),
            .b      (b_in[g]),
            .ca1    (ca1[g]),
            .cb1    (cb1[g]),
            .ca2    (ca2[g]),
            .cb2    (cb2[g]),
            .f      (s_data.factor),
            .eps    (eps_reg),
            .lane_o (lane_o[g])
        );
    end

    // merge: dot sum, square sum for the root, gather lane results
    always_comb begin
        dsum = 66'(lane_o[0].prod) + 66'(lane_o[1].prod)
             + 66'(lane_o[2].prod) + 66'(lane_o[3].prod);
        dsh  = dsum >>> FRAC_BITS;
        dsat = hva_pkg::sat32(68'(dsh));
        qsum = 66'($unsigned(lane_o[0].prod)) + 66'($unsigned(lane_o[1].prod))
             + 66'($unsigned(lane_o[2].prod)) + 66'($unsigned(lane_o[3].prod));
        mrg.op = in2_reg.operation;
        for (int i = 0; i < 4; i++) begin
            mrg.r[i]    = lane_o[i].r;
            mrg.lsat[i] = lane_o[i].sat;
        end
        mrg.eq   = lane_o[0].eq & lane_o[1].eq & lane_o[2].eq & lane_o[3].eq;
        mrg.dot  = dsat.val;
        mrg.dsat = dsat.sat;
        mrg.big  = |qsum[65:64];
        mrg.a[0] = in2_reg.a_x;
        mrg.a[1] = in2_reg.a_y;
        mrg.a[2] = in2_reg.a_z;
        mrg.a[3] = in2_reg.a_w;
        mrg.f    = in2_reg.factor;
        mrg.m    = '0;
    end

    hva_isqrt u_sqrt (
        .aclk     (aclk),
        .en       (adv),
        .n_in     (sqn_reg),
        .root_out (root)
    );

    // divider operands once the magnitude is known
    always_comb begin
        sd_q     = side_reg[SQ];
        m_val    = sd_q.big ? {1'b1, 32'd0} : {1'b0, root};
        fabs     = sd_q.f[31] ? 32'(-sd_q.f) : sd_q.f;
        div_side = sd_q;
        div_side.m = m_val;
        for (int i = 0; i < 4; i++) begin
            aabs[i] = sd_q.a[i][31] ? 32'(-sd_q.a[i]) : sd_q.a[i];
            num[i]  = {aabs[i], {FRAC_BITS{1'b0}}};
            den[i]  = (sd_q.op == hva_pkg::OP_DIV) ? {1'b0, fabs} : m_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sqn_reg     <= qsum[63:0];
            side_reg[0] <= mrg;
            for (int k = 1; k < SIDE_N; k++) begin
                if (k == SQ + 1) begin
                    side_reg[k] <= div_side;
                end else begin
                    side_reg[k] <= side_reg[k-1];
                end
            end
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_div
        hva_div #(
            .NW(DIVN)
        ) u_div (
            .aclk   (aclk),
            .en     (adv),
            .num_in (num[g]),
            .den_in (den[g]),
            .q_out  (quo[g])
        );
    end

    always_comb begin
        sd = side_reg[SIDE_N-1];
        for (int i = 0; i < 4; i++) begin
            neg[i] = sd.a[i][31] ^ ((sd.op == hva_pkg::OP_DIV) && sd.f[31]);
            qv[i]  = neg[i] ? -$signed(68'(quo[i])) : $signed(68'(quo[i]));
            qs[i]  = hva_pkg::sat32(qv[i]);
        end
        out_next = '0;
        sat = 1'b0;
        dz  = 1'b0;
        unique case (sd.op)
            hva_pkg::OP_ADD, hva_pkg::OP_SUB, hva_pkg::OP_NEG, hva_pkg::OP_SCALE: begin
                out_next.res_x = sd.r[0];
                out_next.res_y = sd.r[1];
                out_next.res_z = sd.r[2];
                out_next.res_w = sd.r[3];
                sat = |sd.lsat;
            end
            hva_pkg::OP_DIV: begin
                if (sd.f == '0) begin
                    dz = 1'b1;
                end else begin
                    out_next.res_x = qs[0].val;
                    out_next.res_y = qs[1].val;
                    out_next.res_z = qs[2].val;
                    out_next.res_w = qs[3].val;
                    sat = qs[0].sat | qs[1].sat | qs[2].sat | qs[3].sat;
                end
            end
            hva_pkg::OP_EQ: out_next.is_equal = sd.eq;
            hva_pkg::OP_MAG: begin
                if (sd.m > 33'(hva_pkg::S32_MAX)) begin
                    out_next.res_scalar = 32'(hva_pkg::S32_MAX);
                    sat = 1'b1;
                end else begin
                    out_next.res_scalar = sd.m[31:0];
                end
            end
            hva_pkg::OP_NORM: begin
                if (sd.m == '0) begin
                    dz = 1'b1;
                end else begin
                    out_next.res_x = qs[0].val;
                    out_next.res_y = qs[1].val;
                    out_next.res_z = qs[2].val;
                    sat = qs[0].sat | qs[1].sat | qs[2].sat;
                end
            end
            hva_pkg::OP_DOT: begin
                out_next.res_scalar = sd.dot;
                sat = sd.dsat;
            end
            hva_pkg::OP_CROSS, hva_pkg::OP_CPROD, hva_pkg::OP_BYTES: begin
                out_next.res_x = sd.r[0];
                out_next.res_y = sd.r[1];
                out_next.res_z = sd.r[2];
                sat = |sd.lsat[2:0];
            end
            default: sat = 1'b0;
        endcase
        out_next.status = dz ? hva_pkg::ST_DIVZ : (sat ? hva_pkg::ST_SAT : hva_pkg::ST_OK);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= out_next;
        end
    end

    a_divz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == hva_pkg::ST_DIVZ |->
            m_data.res_x == 0 && m_data.res_y == 0 && m_data.res_z == 0 &&
            m_data.res_w == 0 && m_data.res_scalar == 0)
        else $error("division by zero result not cleared");

    a_eq_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.is_equal |-> m_data.status == hva_pkg::ST_OK)
        else $error("equal flag with non-ok status");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_no_loss: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[LAT-2] && adv |=> m_valid)
        else $error("item lost entering output register");

endmodule
